FILE: sv/flfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flfa_pkg
// Shared types and constants of the free-list fit allocator.
// ----------------------------------------------------------------------------
package flfa_pkg;

	localparam int ARENA_BYTES = 4096;
	localparam int FREE_SLOTS  = 16;
	localparam int PTR_W       = 13;
	localparam int HDR_AW      = $clog2(ARENA_BYTES);
	localparam int ROW_W       = HDR_AW - 2;
	localparam int SLOT_W      = $clog2(FREE_SLOTS);
	localparam int CNT_W       = $clog2(FREE_SLOTS + 1);
	localparam int HDR_BYTES   = 4;

	localparam logic [15:0] MAGIC_RESET = 16'hABCD;

	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_FREE  = 2'd1;
	localparam logic [1:0] FUNC_CHECK = 2'd2;

	localparam logic [1:0] POL_FIRST   = 2'd0;
	localparam logic [1:0] POL_BEST    = 2'd1;
	localparam logic [1:0] POL_NEXT    = 2'd2;
	localparam logic [1:0] POL_INVALID = 2'd3;

	localparam logic REG_FIT_POLICY = 1'b0;
	localparam logic REG_MAGIC      = 1'b1;

	typedef enum logic [2:0] {
		ST_OK,
		ST_NO_FIT,
		ST_BAD_PTR,
		ST_BAD_MAGIC,
		ST_TABLE_FULL,
		ST_BAD_POLICY,
		ST_CHECK_FAIL
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_ALLOC,
		S_FREE_CHK,
		S_POS,
		S_PREV,
		S_NEXT,
		S_DROP,
		S_INS,
		S_CHK_EVAL,
		S_LARGEST,
		S_DONE
	} state_t;

	// element 0 is the byte at the lowest address
	typedef logic [HDR_BYTES-1:0][7:0] hdr_word_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [11:0] request_size;
		logic [12:0] pointer_offset;
		logic [11:0] check_position;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [12:0] payload_offset;
		logic [12:0] freed_bytes;
		logic [4:0]  free_segments;
		logic [12:0] largest_free;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] idx;
		logic [PTR_W-1:0]  start;
		logic [PTR_W-1:0]  len;
	} tbl_wr_t;

endpackage

FILE: sv/flfa_hdr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flfa_hdr_mem
// Header byte store, four byte banks so any four consecutive bytes are read
// or written together. Cleared by a sweep of one row per cycle after reset.
// ----------------------------------------------------------------------------
module flfa_hdr_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [flfa_pkg::HDR_AW-1:0]   rd_addr,
	output flfa_pkg::hdr_word_t           rd_data,
	input  logic                          wr_en,
	input  logic [flfa_pkg::HDR_AW-1:0]   wr_addr,
	input  flfa_pkg::hdr_word_t           wr_data,
	output logic                          clearing
);

	localparam int ROWS = 1 << flfa_pkg::ROW_W;

	logic [flfa_pkg::ROW_W-1:0] clr_q;
	logic                       clearing_q;
	logic [1:0]                 rd_off_q;
	logic [7:0]                 bank_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == flfa_pkg::ROW_W'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign clearing = clearing_q;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [7:0]                  mem [ROWS];
		logic [1:0]                  rj;
		logic [1:0]                  wj;
		logic [flfa_pkg::HDR_AW-1:0] ra;
		logic [flfa_pkg::HDR_AW-1:0] wa;

		assign rj = 2'(b) - rd_addr[1:0];
		assign wj = 2'(b) - wr_addr[1:0];
		assign ra = rd_addr + flfa_pkg::HDR_AW'(rj);
		assign wa = wr_addr + flfa_pkg::HDR_AW'(wj);

		always_ff @(posedge clk) begin
			if (clearing_q) begin
				mem[clr_q] <= 8'h00;
			end else if (wr_en) begin
				mem[wa[flfa_pkg::HDR_AW-1:2]] <= wr_data[wj];
			end
			if (rd_en) begin
				bank_q[b] <= mem[ra[flfa_pkg::HDR_AW-1:2]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_off_q <= rd_addr[1:0];
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			rd_data[j] = bank_q[2'(rd_off_q + 2'(j))];
		end
	end

endmodule

FILE: sv/flfa_seg_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flfa_seg_table
// Free segment table: start and length per slot, one read and one write port.
// ----------------------------------------------------------------------------
module flfa_seg_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [flfa_pkg::SLOT_W-1:0]   rd_idx,
	output logic [flfa_pkg::PTR_W-1:0]    rd_start,
	output logic [flfa_pkg::PTR_W-1:0]    rd_len,
	input  flfa_pkg::tbl_wr_t             wr
);

	logic [flfa_pkg::PTR_W-1:0] start_q [flfa_pkg::FREE_SLOTS];
	logic [flfa_pkg::PTR_W-1:0] len_q   [flfa_pkg::FREE_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < flfa_pkg::FREE_SLOTS; i++) begin
				start_q[i] <= '0;
				len_q[i]   <= '0;
			end
			len_q[0] <= flfa_pkg::PTR_W'(flfa_pkg::ARENA_BYTES);
		end else if (wr.we) begin
			start_q[wr.idx] <= wr.start;
			len_q[wr.idx]   <= wr.len;
		end
	end

	assign rd_start = start_q[rd_idx];
	assign rd_len   = len_q[rd_idx];

endmodule

FILE: sv/free_list_fit_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_fit_allocator_unit
// Free-list allocator over a byte arena: allocate, free with coalescing, check.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on rsp for exactly one cycle with done high and must be captured
// then. Each request walks the segment table one slot per cycle through
// the table's single read port; the table holds at most 16 entries. When an
// allocate uses up its chosen entry, the table is closed up behind it. The
// next request can be taken in the cycle after done. After reset the header
// store is cleared one row per cycle, during which busy is high;
// configuration writes are taken at any time.
module free_list_fit_allocator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  flfa_pkg::req_t     req,
	output logic               done,
	output flfa_pkg::rsp_t     rsp,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [15:0]        cfg_data
);

	localparam int PW = flfa_pkg::PTR_W;
	localparam int CW = flfa_pkg::CNT_W;
	localparam int SW = flfa_pkg::SLOT_W;

	flfa_pkg::state_t  state_q, state_d;
	flfa_pkg::req_t    req_q;
	flfa_pkg::status_t status_q;
	flfa_pkg::tbl_wr_t tbl_wr;
	flfa_pkg::hdr_word_t hdr_rd, hdr_wd;

	logic [1:0]    pol_q;
	logic [15:0]   magic_q;
	logic [CW-1:0] cnt_q, k_q, pos_q;
	logic [SW-1:0] nf_q, idx_q, fidx_q;
	logic          found_q, mprev_q;
	logic [PW-1:0] total_q, flen_q, nl_q, pstart_q, plen_q;
	logic [PW-1:0] payload_q, freed_q, lg_q;

	logic [SW-1:0] rd_idx;
	logic [PW-1:0] rd_start, rd_len;
	logic          hdr_rd_en, hdr_wr_en, clearing;
	logic [flfa_pkg::HDR_AW-1:0] hdr_wa;

	logic          accept, ptr_ok, fits, k_end, magic_hit, mprev, mnext, full;
	logic          both, neither;
	logic [PW-1:0] ns, limit, nl_clip;
	logic [15:0]   size16, total16;
	logic [CW-1:0] k_inc, k_dec, pos_dec;

	assign busy   = (state_q != flfa_pkg::S_IDLE) || clearing;
	assign accept = start && !busy;

	assign k_inc   = k_q + 1'b1;
	assign k_dec   = k_q - 1'b1;
	assign pos_dec = pos_q - 1'b1;

	assign ns      = req_q.pointer_offset - PW'(flfa_pkg::HDR_BYTES);
	assign ptr_ok  = (req_q.pointer_offset >= PW'(flfa_pkg::HDR_BYTES)) &&
	                 (req_q.pointer_offset <= PW'(flfa_pkg::ARENA_BYTES));
	assign fits    = rd_len >= total_q;
	assign k_end   = k_q == cnt_q;
	assign full    = cnt_q >= CW'(flfa_pkg::FREE_SLOTS);

	assign magic_hit = {hdr_rd[2], hdr_rd[3]} == magic_q;
	assign size16    = {hdr_rd[0], hdr_rd[1]};
	assign total16   = 16'(total_q);
	assign limit     = PW'(flfa_pkg::ARENA_BYTES) - ns;
	assign nl_clip   = (size16 > 16'(limit)) ? limit : size16[PW-1:0];

	assign mprev   = (pos_q != '0) &&
	                 (({1'b0, rd_start} + {1'b0, rd_len}) == {1'b0, ns});
	assign mnext   = (pos_q < cnt_q) &&
	                 (({1'b0, ns} + {1'b0, nl_q}) == {1'b0, rd_start});
	assign both    = mprev_q && mnext;
	assign neither = !mprev_q && !mnext;

	flfa_seg_table u_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx),
		.rd_start (rd_start),
		.rd_len   (rd_len),
		.wr       (tbl_wr)
	);

	flfa_hdr_mem u_hdr (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (hdr_rd_en),
		.rd_addr  (ns[flfa_pkg::HDR_AW-1:0]),
		.rd_data  (hdr_rd),
		.wr_en    (hdr_wr_en),
		.wr_addr  (hdr_wa),
		.wr_data  (hdr_wd),
		.clearing (clearing)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			flfa_pkg::S_IDLE:
				if (accept) state_d = flfa_pkg::S_DISPATCH;
			flfa_pkg::S_DISPATCH: begin
				case (req_q.func)
					flfa_pkg::FUNC_ALLOC:
						state_d = (pol_q == flfa_pkg::POL_INVALID) ?
						          flfa_pkg::S_LARGEST : flfa_pkg::S_SCAN;
					flfa_pkg::FUNC_FREE:
						state_d = ptr_ok ? flfa_pkg::S_FREE_CHK : flfa_pkg::S_LARGEST;
					flfa_pkg::FUNC_CHECK:
						state_d = ptr_ok ? flfa_pkg::S_CHK_EVAL : flfa_pkg::S_LARGEST;
					default:
						state_d = flfa_pkg::S_LARGEST;
				endcase
			end
			flfa_pkg::S_SCAN: begin
				if (k_end) begin
					state_d = found_q ? flfa_pkg::S_ALLOC : flfa_pkg::S_LARGEST;
				end else if (fits && pol_q != flfa_pkg::POL_BEST) begin
					state_d = flfa_pkg::S_ALLOC;
				end
			end
			flfa_pkg::S_ALLOC:
				state_d = (rd_len == total_q) ? flfa_pkg::S_DROP : flfa_pkg::S_LARGEST;
			flfa_pkg::S_FREE_CHK: begin
				if (!magic_hit || nl_clip == '0) state_d = flfa_pkg::S_LARGEST;
				else state_d = flfa_pkg::S_POS;
			end
			flfa_pkg::S_POS:
				if (!(pos_q < cnt_q && rd_start <= ns)) state_d = flfa_pkg::S_PREV;
			flfa_pkg::S_PREV:
				state_d = flfa_pkg::S_NEXT;
			flfa_pkg::S_NEXT: begin
				if (both) state_d = flfa_pkg::S_DROP;
				else if (neither && !full) state_d = flfa_pkg::S_INS;
				else state_d = flfa_pkg::S_LARGEST;
			end
			flfa_pkg::S_DROP:
				if (!(k_inc < cnt_q)) state_d = flfa_pkg::S_LARGEST;
			flfa_pkg::S_INS:
				if (!(k_q > pos_q)) state_d = flfa_pkg::S_LARGEST;
			flfa_pkg::S_CHK_EVAL:
				state_d = flfa_pkg::S_LARGEST;
			flfa_pkg::S_LARGEST:
				if (k_end) state_d = flfa_pkg::S_DONE;
			flfa_pkg::S_DONE:
				state_d = flfa_pkg::S_IDLE;
			default:
				state_d = flfa_pkg::S_IDLE;
		endcase
	end

	// table and header port control
	always_comb begin
		rd_idx    = '0;
		tbl_wr    = '0;
		hdr_rd_en = 1'b0;
		hdr_wr_en = 1'b0;
		hdr_wa    = ns[flfa_pkg::HDR_AW-1:0];
		hdr_wd    = '0;
		case (state_q)
			flfa_pkg::S_DISPATCH:
				hdr_rd_en = 1'b1;
			flfa_pkg::S_SCAN:
				rd_idx = idx_q;
			flfa_pkg::S_ALLOC: begin
				rd_idx    = fidx_q;
				hdr_wr_en = 1'b1;
				hdr_wa    = rd_start[flfa_pkg::HDR_AW-1:0];
				hdr_wd[0] = total16[15:8];
				hdr_wd[1] = total16[7:0];
				hdr_wd[2] = magic_q[15:8];
				hdr_wd[3] = magic_q[7:0];
				if (rd_len != total_q) begin
					tbl_wr.we    = 1'b1;
					tbl_wr.idx   = fidx_q;
					tbl_wr.start = rd_start + total_q;
					tbl_wr.len   = rd_len - total_q;
				end
			end
			flfa_pkg::S_FREE_CHK:
				hdr_wr_en = magic_hit && (nl_clip == '0);
			flfa_pkg::S_POS:
				rd_idx = pos_q[SW-1:0];
			flfa_pkg::S_PREV:
				rd_idx = pos_dec[SW-1:0];
			flfa_pkg::S_NEXT: begin
				rd_idx    = pos_q[SW-1:0];
				hdr_wr_en = !(neither && full);
				if (mprev_q) begin
					tbl_wr.we    = 1'b1;
					tbl_wr.idx   = pos_dec[SW-1:0];
					tbl_wr.start = pstart_q;
					tbl_wr.len   = both ? (plen_q + nl_q + rd_len) : (plen_q + nl_q);
				end else if (mnext) begin
					tbl_wr.we    = 1'b1;
					tbl_wr.idx   = pos_q[SW-1:0];
					tbl_wr.start = ns;
					tbl_wr.len   = rd_len + nl_q;
				end
			end
			flfa_pkg::S_DROP: begin
				rd_idx = k_inc[SW-1:0];
				if (k_inc < cnt_q) begin
					tbl_wr.we    = 1'b1;
					tbl_wr.idx   = k_q[SW-1:0];
					tbl_wr.start = rd_start;
					tbl_wr.len   = rd_len;
				end
			end
			flfa_pkg::S_INS: begin
				rd_idx    = k_dec[SW-1:0];
				tbl_wr.we = 1'b1;
				if (k_q > pos_q) begin
					tbl_wr.idx   = k_q[SW-1:0];
					tbl_wr.start = rd_start;
					tbl_wr.len   = rd_len;
				end else begin
					tbl_wr.idx   = pos_q[SW-1:0];
					tbl_wr.start = ns;
					tbl_wr.len   = nl_q;
				end
			end
			flfa_pkg::S_LARGEST:
				rd_idx = k_q[SW-1:0];
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flfa_pkg::S_IDLE;
			pol_q   <= flfa_pkg::POL_FIRST;
			magic_q <= flfa_pkg::MAGIC_RESET;
			cnt_q   <= CW'(1);
			nf_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					flfa_pkg::REG_FIT_POLICY: pol_q   <= cfg_data[1:0];
					flfa_pkg::REG_MAGIC:      magic_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == flfa_pkg::S_DROP && !(k_inc < cnt_q)) cnt_q <= cnt_q - 1'b1;
			if (state_q == flfa_pkg::S_INS && !(k_q > pos_q)) cnt_q <= cnt_q + 1'b1;
			if (state_q == flfa_pkg::S_ALLOC && pol_q == flfa_pkg::POL_NEXT) nf_q <= fidx_q;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			flfa_pkg::S_IDLE: begin
				if (accept) begin
					req_q     <= req;
					status_q  <= flfa_pkg::ST_OK;
					payload_q <= '0;
					freed_q   <= '0;
					found_q   <= 1'b0;
					total_q   <= PW'(req.request_size) + PW'(flfa_pkg::HDR_BYTES);
				end
			end
			flfa_pkg::S_DISPATCH: begin
				pos_q <= '0;
				idx_q <= (pol_q == flfa_pkg::POL_NEXT && {1'b0, nf_q} < cnt_q) ? nf_q : '0;
				case (req_q.func)
					flfa_pkg::FUNC_ALLOC:
						if (pol_q == flfa_pkg::POL_INVALID) status_q <= flfa_pkg::ST_BAD_POLICY;
					flfa_pkg::FUNC_FREE, flfa_pkg::FUNC_CHECK:
						if (!ptr_ok) status_q <= flfa_pkg::ST_BAD_PTR;
					default:
						status_q <= flfa_pkg::ST_BAD_POLICY;
				endcase
			end
			flfa_pkg::S_SCAN: begin
				if (k_end) begin
					if (!found_q) status_q <= flfa_pkg::ST_NO_FIT;
				end else if (fits && pol_q != flfa_pkg::POL_BEST) begin
					found_q <= 1'b1;
					fidx_q  <= idx_q;
				end else begin
					if (fits && (!found_q || rd_len < flen_q)) begin
						found_q <= 1'b1;
						fidx_q  <= idx_q;
						flen_q  <= rd_len;
					end
					idx_q <= ({1'b0, idx_q} + 1'b1 == cnt_q) ? '0 : idx_q + 1'b1;
				end
			end
			flfa_pkg::S_ALLOC:
				payload_q <= rd_start + PW'(flfa_pkg::HDR_BYTES);
			flfa_pkg::S_FREE_CHK: begin
				nl_q <= nl_clip;
				if (!magic_hit) status_q <= flfa_pkg::ST_BAD_MAGIC;
			end
			flfa_pkg::S_POS:
				if (pos_q < cnt_q && rd_start <= ns) pos_q <= pos_q + 1'b1;
			flfa_pkg::S_PREV: begin
				mprev_q  <= mprev;
				pstart_q <= rd_start;
				plen_q   <= rd_len;
			end
			flfa_pkg::S_NEXT: begin
				if (neither && full) begin
					status_q <= flfa_pkg::ST_TABLE_FULL;
				end else begin
					freed_q <= nl_q;
				end
			end
			flfa_pkg::S_CHK_EVAL: begin
				if (!magic_hit || size16 < 16'(req_q.check_position)) begin
					status_q <= flfa_pkg::ST_CHECK_FAIL;
				end else begin
					payload_q <= req_q.pointer_offset;
				end
			end
			default: ;
		endcase
	end

	// slot counter and largest segment
	always_ff @(posedge clk) begin
		if (state_d == flfa_pkg::S_LARGEST && state_q != flfa_pkg::S_LARGEST) begin
			k_q  <= '0;
			lg_q <= '0;
		end else begin
			case (state_q)
				flfa_pkg::S_DISPATCH:
					k_q <= '0;
				flfa_pkg::S_SCAN:
					if (!k_end && !(fits && pol_q != flfa_pkg::POL_BEST)) k_q <= k_inc;
				flfa_pkg::S_ALLOC:
					k_q <= CW'(fidx_q);
				flfa_pkg::S_NEXT:
					k_q <= both ? pos_q : cnt_q;
				flfa_pkg::S_DROP:
					k_q <= k_inc;
				flfa_pkg::S_INS:
					k_q <= k_dec;
				flfa_pkg::S_LARGEST: begin
					k_q <= k_inc;
					if (!k_end && rd_len > lg_q) lg_q <= rd_len;
				end
				default: ;
			endcase
		end
	end

	assign done               = state_q == flfa_pkg::S_DONE;
	assign rsp.status         = status_q;
	assign rsp.payload_offset = payload_q;
	assign rsp.freed_bytes    = freed_q;
	assign rsp.free_segments  = cnt_q;
	assign rsp.largest_free   = lg_q;

endmodule

FILE: sv/flfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flfa_checker
// Port-level checks of the allocator's request and result timing.
// ----------------------------------------------------------------------------
module flfa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input flfa_pkg::rsp_t rsp
);

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken without busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result while idle");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.free_segments <= 5'(flfa_pkg::FREE_SLOTS))
		else $error("segment count out of range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != flfa_pkg::ST_OK |->
		rsp.freed_bytes == '0 && rsp.payload_offset == '0)
		else $error("failed request returned data");

endmodule

bind free_list_fit_allocator_unit flfa_checker u_flfa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
